// ===== src/lskv_pkg.sv =====
package lskv_pkg;

  typedef enum logic [1:0] {
    FUNC_FIND   = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_DELETE = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    RES_OK        = 2'd0,
    RES_NOT_FOUND = 2'd1,
    RES_DUPLICATE = 2'd2,
    RES_FULL      = 2'd3
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_RESULT
  } state_t;

  localparam int unsigned FUNC_BITS   = 2;
  localparam int unsigned STATUS_BITS = 2;
  localparam int unsigned COUNT_BITS  = 32;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic scan;
    logic count_cmp;
    logic capture_hit;
    logic capture_miss;
    logic ins_write;
    logic del_read;
    logic del_write;
    logic set_status;
    res_t status;
    logic load_out;
  } lskv_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [FUNC_BITS-1:0] func;
    logic match;
    logic miss;
    logic found;
    logic full;
    logic out_busy;
  } lskv_stat_t;

endpackage

// ===== src/linear_scan_key_value_table_top.sv =====
// Unsorted key/value table with find, insert and delete. Every operation scans the
// filled entries from index 0, one key compare per cycle through the single read port
// of the key memory, and stops at the first match, so it compares at most the filled
// count of entries. A delete that hits then reads the last entry and moves it into the
// freed slot. One operation is in flight at a time; its result sits in an output
// register so the next operation can be accepted while it waits. access_count counts
// every compared entry plus one per completed insert or delete, and wraps at 32 bits.
// No clearing pass is needed after reset.
module linear_scan_key_value_table_top
  import lskv_pkg::*;
#(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32,
  localparam int unsigned POS_BITS  = $clog2(CAPACITY + 1),
  localparam int unsigned S_BITS    = ((FUNC_BITS + KEY_BITS + VALUE_BITS + 7) / 8) * 8,
  localparam int unsigned M_BITS    = ((STATUS_BITS + POS_BITS + COUNT_BITS + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [S_BITS-1:0] s_tdata,   // func, key, value
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [M_BITS-1:0] m_tdata    // status, position, access_count
);

  localparam int unsigned M_USED = STATUS_BITS + POS_BITS + COUNT_BITS;

  lskv_cmd_t               cmd;
  lskv_stat_t              stat;
  logic [STATUS_BITS-1:0]  out_status;
  logic [POS_BITS-1:0]     out_position;
  logic [COUNT_BITS-1:0]   out_count;

  lskv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lskv_datapath #(
    .CAPACITY   (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_func      (s_tdata[FUNC_BITS-1:0]),
    .in_key       (s_tdata[FUNC_BITS +: KEY_BITS]),
    .in_value     (s_tdata[FUNC_BITS+KEY_BITS +: VALUE_BITS]),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_status   (out_status),
    .out_position (out_position),
    .out_count    (out_count)
  );

  assign m_tdata = {{(M_BITS - M_USED){1'b0}}, out_count, out_position, out_status};

endmodule

// ===== src/lskv_ctrl.sv =====
module lskv_ctrl
  import lskv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  lskv_stat_t stat,
  output lskv_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.match || stat.miss) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (stat.func == FUNC_DELETE && stat.found) state_next = ST_MOVE_RD;
        else state_next = ST_RESULT;
      end
      ST_MOVE_RD: state_next = ST_MOVE_WR;
      ST_MOVE_WR: state_next = ST_RESULT;
      ST_RESULT: begin
        if (!stat.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.status   = RES_OK;
    in_ready     = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      ST_SCAN: begin
        cmd.scan      = 1'b1;
        cmd.count_cmp = 1'b1;
        // first match wins over the end-of-scan miss
        if (stat.match) cmd.capture_hit = 1'b1;
        else if (stat.miss) cmd.capture_miss = 1'b1;
      end
      ST_DECIDE: begin
        cmd.set_status = 1'b1;
        case (stat.func)
          FUNC_INSERT: begin
            if (stat.found) begin
              cmd.status = RES_DUPLICATE;
            end else if (stat.full) begin
              cmd.status = RES_FULL;
            end else begin
              cmd.status    = RES_OK;
              cmd.ins_write = 1'b1;
            end
          end
          FUNC_DELETE: begin
            cmd.status = stat.found ? RES_OK : RES_NOT_FOUND;
          end
          default: begin
            cmd.status = stat.found ? RES_OK : RES_NOT_FOUND;
          end
        endcase
      end
      ST_MOVE_RD: cmd.del_read = 1'b1;
      ST_MOVE_WR: cmd.del_write = 1'b1;
      ST_RESULT: cmd.load_out = !stat.out_busy;
      default: ;
    endcase
  end

endmodule

// ===== src/lskv_datapath.sv =====
module lskv_datapath
  import lskv_pkg::*;
#(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32,
  localparam int unsigned POS_BITS  = $clog2(CAPACITY + 1),
  localparam int unsigned IDX_BITS  = $clog2(CAPACITY)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  lskv_cmd_t              cmd,
  output lskv_stat_t             stat,
  input  logic [FUNC_BITS-1:0]   in_func,
  input  logic [KEY_BITS-1:0]    in_key,
  input  logic [VALUE_BITS-1:0]  in_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [STATUS_BITS-1:0] out_status,
  output logic [POS_BITS-1:0]    out_position,
  output logic [COUNT_BITS-1:0]  out_count
);

  logic [KEY_BITS-1:0]    key_mem [CAPACITY];
  logic [VALUE_BITS-1:0]  val_mem [CAPACITY];

  logic [FUNC_BITS-1:0]   func;
  logic [KEY_BITS-1:0]    key;
  logic [VALUE_BITS-1:0]  value;
  logic [POS_BITS-1:0]    scan_idx;
  logic [POS_BITS-1:0]    cmp_idx;
  logic                   cmp_valid;
  logic [POS_BITS-1:0]    filled;
  logic [COUNT_BITS-1:0]  acc;
  logic                   found;
  logic [POS_BITS-1:0]    pos;
  logic [STATUS_BITS-1:0] res_status;
  logic [KEY_BITS-1:0]    rkey;
  logic [VALUE_BITS-1:0]  rvalue;

  logic [POS_BITS-1:0]    filled_m1;
  logic [IDX_BITS-1:0]    raddr;
  logic [IDX_BITS-1:0]    waddr;
  logic                   we;
  logic [KEY_BITS-1:0]    wkey;
  logic [VALUE_BITS-1:0]  wvalue;
  logic                   match;

  assign filled_m1 = filled - POS_BITS'(1);
  assign raddr     = cmd.del_read ? filled_m1[IDX_BITS-1:0] : scan_idx[IDX_BITS-1:0];
  assign we        = cmd.ins_write || cmd.del_write;
  assign waddr     = cmd.ins_write ? filled[IDX_BITS-1:0] : pos[IDX_BITS-1:0];
  assign wkey      = cmd.ins_write ? key : rkey;
  assign wvalue    = cmd.ins_write ? value : rvalue;
  assign match     = cmp_valid && (rkey == key);

  assign stat.func     = func;
  assign stat.match    = match;
  assign stat.miss     = (filled == '0) || (cmp_valid && cmp_idx == filled_m1 && !match);
  assign stat.found    = found;
  assign stat.full     = (filled == POS_BITS'(CAPACITY));
  assign stat.out_busy = out_valid && !out_ready;

  // single read port shared by the scan and the delete move
  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr] <= wkey;
      val_mem[waddr] <= wvalue;
    end
    rkey   <= key_mem[raddr];
    rvalue <= val_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      func  <= in_func;
      key   <= in_key;
      value <= in_value;
    end
    if (cmd.start) begin
      scan_idx <= '0;
    end else if (cmd.scan && scan_idx < filled) begin
      scan_idx <= scan_idx + POS_BITS'(1);
      cmp_idx  <= scan_idx;
    end
    if (cmd.capture_hit) begin
      found <= 1'b1;
      pos   <= cmp_idx;
    end else if (cmd.capture_miss) begin
      found <= 1'b0;
      pos   <= filled;
    end
    if (cmd.set_status) res_status <= cmd.status;
    if (cmd.load_out) begin
      out_status   <= res_status;
      out_position <= pos;
      out_count    <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
      filled    <= '0;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      cmp_valid <= cmd.scan && !cmd.start && (scan_idx < filled);
      if (cmd.ins_write) filled <= filled + POS_BITS'(1);
      else if (cmd.del_write) filled <= filled_m1;
      if ((cmd.count_cmp && cmp_valid) || we) acc <= acc + COUNT_BITS'(1);
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

// ===== src/lskv_checker.sv =====
module lskv_assertions
  import lskv_pkg::*;
#(
  parameter int unsigned CAPACITY   = 64,
  localparam int unsigned POS_BITS  = $clog2(CAPACITY + 1),
  localparam int unsigned M_BITS    = ((STATUS_BITS + POS_BITS + COUNT_BITS + 7) / 8) * 8
) (
  input logic              clk,
  input logic              rst,
  input logic              s_tvalid,
  input logic              s_tready,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [M_BITS-1:0] m_tdata
);

  logic       in_hs;
  logic       out_hs;
  logic [1:0] pending;

  assign in_hs  = s_tvalid && s_tready;
  assign out_hs = m_tvalid && m_tready;

  // transactions accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_hs && !out_hs) begin
      pending <= pending + 2'd1;
    end else if (out_hs && !in_hs) begin
      pending <= pending - 2'd1;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_hs |=> !s_tready)
    else $error("second operation accepted while one is in progress");

  a_position_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[STATUS_BITS +: POS_BITS] <= POS_BITS'(CAPACITY))
    else $error("position beyond capacity");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_hs |-> pending != 2'd0)
    else $error("result delivered without an accepted operation");

  a_bounded_pending: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more than two operations outstanding");

endmodule

bind linear_scan_key_value_table_top lskv_assertions #(
  .CAPACITY   (CAPACITY)
) u_lskv_assertions (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== test/lskv_checker.sv =====
module lskv_checker
  import lskv_pkg::*;
#(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned POS_BITS   = 7,
  parameter int unsigned S_BITS     = 72,
  parameter int unsigned M_BITS     = 48
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [S_BITS-1:0] s_tdata,   // func, key, value
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [M_BITS-1:0] m_tdata,   // status, position, access_count
  output int                errors,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned KEY_LO = FUNC_BITS;
  localparam int unsigned VAL_LO = FUNC_BITS + KEY_BITS;
  localparam int unsigned POS_LO = STATUS_BITS;
  localparam int unsigned CNT_LO = STATUS_BITS + POS_BITS;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [POS_BITS-1:0]    position;
    logic [COUNT_BITS-1:0]  access_count;
  } table_reply_t;

  // mirror of the table contents
  logic [KEY_BITS-1:0]   key_store [CAPACITY];
  logic [VALUE_BITS-1:0] value_store [CAPACITY];
  int unsigned           fill_cnt;
  logic [COUNT_BITS-1:0] access_cnt;

  table_reply_t expected_replies [$];

  initial begin
    errors     = 0;
    pending    = 0;
    fill_cnt   = 0;
    access_cnt = '0;
  end

  task automatic scan_table_op(input logic [FUNC_BITS-1:0] op, input logic [KEY_BITS-1:0] k,
                               input logic [VALUE_BITS-1:0] v, output table_reply_t r);
    int unsigned idx;
    bit          hit;
    idx = 0;
    hit = 1'b0;
    while (idx < fill_cnt && !hit) begin
      access_cnt = access_cnt + 1'b1;
      if (key_store[idx] == k) hit = 1'b1;
      else idx++;
    end
    // on a miss idx has reached the filled count
    r.position = idx[POS_BITS-1:0];
    case (op)
      FUNC_INSERT: begin
        if (hit) begin
          r.status = RES_DUPLICATE;
        end else if (fill_cnt >= CAPACITY) begin
          r.status = RES_FULL;
        end else begin
          key_store[fill_cnt]   = k;
          value_store[fill_cnt] = v;
          fill_cnt++;
          access_cnt = access_cnt + 1'b1;
          r.status = RES_OK;
        end
      end
      FUNC_DELETE: begin
        if (hit) begin
          // last filled entry fills the hole, possibly onto itself
          key_store[idx]   = key_store[fill_cnt-1];
          value_store[idx] = value_store[fill_cnt-1];
          fill_cnt--;
          access_cnt = access_cnt + 1'b1;
          r.status = RES_OK;
        end else begin
          r.status = RES_NOT_FOUND;
        end
      end
      default: r.status = hit ? RES_OK : RES_NOT_FOUND;
    endcase
    r.access_count = access_cnt;
  endtask

  always @(posedge clk) begin
    table_reply_t want;
    table_reply_t got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        scan_table_op(s_tdata[FUNC_BITS-1:0], s_tdata[KEY_LO +: KEY_BITS],
                      s_tdata[VAL_LO +: VALUE_BITS], want);
        expected_replies.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got.status       = m_tdata[STATUS_BITS-1:0];
        got.position     = m_tdata[POS_LO +: POS_BITS];
        got.access_count = m_tdata[CNT_LO +: COUNT_BITS];
        if (expected_replies.size() == 0) begin
          $display("%0t: extra result transaction, expected none, got %0d/%0d/%0d",
                   $realtime, got.status, got.position, got.access_count);
          errors = errors + 1;
        end else begin
          want = expected_replies.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $realtime, want.status, got.status);
            errors = errors + 1;
          end
          if (got.position !== want.position) begin
            $display("%0t: position mismatch, expected %0d, got %0d",
                     $realtime, want.position, got.position);
            errors = errors + 1;
          end
          if (got.access_count !== want.access_count) begin
            $display("%0t: access_count mismatch, expected %0d, got %0d",
                     $realtime, want.access_count, got.access_count);
            errors = errors + 1;
          end
        end
      end
      pending = expected_replies.size();
    end
  end

endmodule

// ===== test/linear_scan_key_value_table_top_tb.sv =====
module linear_scan_key_value_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lskv_pkg::*;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned POS_BITS = 7;
  localparam int unsigned S_BITS   = 72;
  localparam int unsigned M_BITS   = 48;
  localparam int unsigned KEY_POOL = 96;
  localparam int unsigned N_RANDOM = 1700;
  // spare operation code, handled as a find
  localparam logic [FUNC_BITS-1:0] FUNC_UNUSED = 2'd3;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [S_BITS-1:0] s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [M_BITS-1:0] m_tdata;

  int          errors;
  int          pending;
  int unsigned send_idle_pct = 36;
  int unsigned recv_idle_pct = 85;
  logic [31:0] key_pool [KEY_POOL];

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  linear_scan_key_value_table_top #(.CAPACITY(CAPACITY)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  lskv_checker #(
    .CAPACITY(CAPACITY), .POS_BITS(POS_BITS), .S_BITS(S_BITS), .M_BITS(M_BITS)
  ) u_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .errors(errors), .pending(pending)
  );

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_op(input logic [FUNC_BITS-1:0] op, input logic [31:0] k,
                         input logic [31:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_BITS-66){1'b0}}, v, k, op};
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic logic [31:0] pick_key();
    if ($urandom_range(9) == 0) return $urandom;
    return key_pool[$urandom_range(KEY_POOL-1)];
  endfunction

  initial begin
    logic [FUNC_BITS-1:0] op;
    int unsigned          roll;
    int unsigned          mode;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hffff_ffff;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // empty table, extremes, duplicate, spare code, delete cases
    send_op(FUNC_FIND,   32'h0000_0000, 32'h0000_0000);
    send_op(FUNC_DELETE, 32'h0000_1234, 32'hffff_ffff);
    send_op(FUNC_INSERT, 32'h0000_0000, 32'hffff_ffff);
    send_op(FUNC_INSERT, 32'hffff_ffff, 32'h0000_0000);
    send_op(FUNC_INSERT, 32'h5a5a_5a5a, 32'ha5a5_a5a5);
    send_op(FUNC_INSERT, 32'h0000_0000, 32'h1234_5678);
    send_op(FUNC_FIND,   32'hffff_ffff, 32'h0000_0000);
    send_op(FUNC_UNUSED, 32'h5a5a_5a5a, 32'h0000_0000);
    send_op(FUNC_UNUSED, 32'h0000_0077, 32'h0000_0000);
    send_op(FUNC_DELETE, 32'h0000_0000, 32'h0000_0000);
    send_op(FUNC_FIND,   32'h5a5a_5a5a, 32'h0000_0000);
    send_op(FUNC_DELETE, 32'hdead_beef, 32'h0000_0000);
    send_op(FUNC_DELETE, 32'hffff_ffff, 32'h0000_0000);
    send_op(FUNC_INSERT, 32'h8000_0000, 32'h7fff_ffff);
    send_op(FUNC_DELETE, 32'h5a5a_5a5a, 32'h0000_0000);
    send_op(FUNC_DELETE, 32'h8000_0000, 32'h0000_0000);
    send_op(FUNC_FIND,   32'h8000_0000, 32'h0000_0000);
    send_op(FUNC_INSERT, 32'h0000_0001, 32'h0000_0001);
    send_op(FUNC_FIND,   32'h0000_0001, 32'h0000_0000);

    for (int unsigned i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 3) begin
        send_idle_pct = 85;
        recv_idle_pct = 36;
      end else if (i == 2 * N_RANDOM / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // alternate fill, drain and mixed stretches so full and empty both recur
      mode = (i / 120) % 3;
      roll = $urandom_range(99);
      case (mode)
        0:       op = (roll < 85) ? FUNC_INSERT : (roll < 90) ? FUNC_DELETE : FUNC_FIND;
        1:       op = (roll < 10) ? FUNC_INSERT : (roll < 85) ? FUNC_DELETE : FUNC_FIND;
        default: op = (roll < 40) ? FUNC_INSERT : (roll < 70) ? FUNC_DELETE : FUNC_FIND;
      endcase
      if (op == FUNC_FIND && $urandom_range(7) == 0) op = FUNC_UNUSED;
      send_op(op, pick_key(), $urandom);
    end
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
src/lskv_pkg.sv
src/lskv_ctrl.sv
src/lskv_datapath.sv
src/linear_scan_key_value_table_top.sv
src/lskv_checker.sv
test/lskv_checker.sv
test/linear_scan_key_value_table_top_tb.sv
